/* hdl/psf_pkg.sv */
// shared types, constants and codes of the polymorphic site filter
`timescale 1ns / 1ps
`default_nettype none
package psf_pkg;

	localparam int MAX_HAPLOTYPES = 4096;
	localparam int WORD_W         = 64;
	localparam int SITE_LENGTH_W  = 13;
	localparam int COUNT_W        = 13;
	localparam int TOTAL_W        = 32;
	localparam int ONES_W         = 7;
	localparam int QUEUE_DEPTH    = 4;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 13;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_SITE_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_REMOVE      = 2'd1;

	localparam logic [SITE_LENGTH_W-1:0] SITE_LENGTH_RESET = 13'd4096;

	// -1.0 in signed q32.32
	localparam logic signed [WORD_W-1:0] GEN_RESET = 64'hFFFF_FFFF_0000_0000;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef enum logic [1:0] {
		CLASS_KEPT          = 2'd0,
		CLASS_MONO          = 2'd1,
		CLASS_NON_DIVERGING = 2'd2
	} site_class_t;

	// one input item
	typedef struct packed {
		logic        [WORD_W-1:0] haplotype_word;
		logic signed [WORD_W-1:0] gen_position;
	} site_word_t;

	// one result item
	typedef struct packed {
		logic                 site_kept;
		site_class_t          site_class;
		logic [COUNT_W-1:0]   allele_count;
		logic [TOTAL_W-1:0]   kept_total;
		logic [TOTAL_W-1:0]   non_diverging_total;
	} verdict_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [ONES_W-1:0]        ones;
		logic                     differs;
		logic                     last;
		logic signed [WORD_W-1:0] gen_position;
	} word_info_t;

endpackage
`default_nettype wire

/* hdl/psf_front.sv */
// front end: word position, masking, previous-site store and classification
`timescale 1ns / 1ps
`default_nettype none
module psf_front #(
	parameter int MAX_HAPLOTYPES = psf_pkg::MAX_HAPLOTYPES
) (
	input  wire  logic                                       clk,
	input  wire  logic                                       arst_n,
	input  wire  logic                                       push,
	output logic                                             full,
	input  wire  psf_pkg::site_word_t                        site,
	input  wire  logic [$clog2(MAX_HAPLOTYPES+1)-1:0]        len,
	input  wire  logic                                       q_full,
	output logic                                             q_push,
	output psf_pkg::word_info_t                              q_item
);

	localparam int LW        = $clog2(MAX_HAPLOTYPES + 1);
	localparam int WORDS_MAX = MAX_HAPLOTYPES / psf_pkg::WORD_W;
	localparam int PW        = (WORDS_MAX > 1) ? $clog2(WORDS_MAX) : 1;
	localparam int WW        = psf_pkg::WORD_W;

	function automatic logic [psf_pkg::ONES_W-1:0] pop64(input logic [WW-1:0] v);
		logic [3:0]                  byte_ones [8];
		logic [psf_pkg::ONES_W-1:0]  total;
		for (int b = 0; b < 8; b++) begin
			byte_ones[b] = '0;
			for (int i = 0; i < 8; i++) begin
				byte_ones[b] = byte_ones[b] + 4'(v[b*8+i]);
			end
		end
		total = '0;
		for (int b = 0; b < 8; b++) begin
			total = total + psf_pkg::ONES_W'(byte_ones[b]);
		end
		return total;
	endfunction

	logic [PW-1:0]        pos_q;
	logic [WORDS_MAX-1:0] written_q;
	logic [WW-1:0]        mem [WORDS_MAX];

	logic                        valid_s1;
	logic [WW-1:0]               word_s1;
	logic [WW-1:0]               prev_s1;
	logic                        prev_written_s1;
	logic                        last_s1;
	logic signed [WW-1:0]        gen_s1;

	logic [LW-1:0] len_m1;
	logic [PW-1:0] last_idx;
	logic          is_last;
	logic [PW-1:0] pos_eff;
	logic [WW-1:0] mask;
	logic [WW-1:0] word_m;
	logic          accept;

	always_comb begin
		len_m1   = len - LW'(1);
		last_idx = PW'(len_m1 >> 6);
		is_last  = (pos_q >= last_idx);
		pos_eff  = is_last ? last_idx : pos_q;
		// only the last word of a site can hold stray bits
		mask     = is_last ? ({WW{1'b1}} >> (6'd63 - len_m1[5:0])) : {WW{1'b1}};
		word_m   = site.haplotype_word & mask;
	end

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;

	always_comb begin
		q_item.ones         = pop64(word_s1);
		q_item.differs      = |(word_s1 ^ (prev_written_s1 ? prev_s1 : '0));
		q_item.last         = last_s1;
		q_item.gen_position = gen_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			written_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (accept) begin
				pos_q              <= is_last ? '0 : pos_eff + PW'(1);
				written_q[pos_eff] <= 1'b1;
				valid_s1           <= 1'b1;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// read-first store of the previous site, read data registered
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_s1         <= mem[pos_eff];
			mem[pos_eff]    <= word_m;
			prev_written_s1 <= written_q[pos_eff];
			word_s1         <= word_m;
			last_s1         <= is_last;
			gen_s1          <= site.gen_position;
		end
	end

endmodule
`default_nettype wire

/* hdl/psf_queue.sv */
// short queue of classified words between front and back
`timescale 1ns / 1ps
`default_nettype none
module psf_queue (
	input  wire  logic                 clk,
	input  wire  logic                 arst_n,
	input  wire  logic                 wr_en,
	input  wire  psf_pkg::word_info_t  wr_item,
	output logic                       full,
	input  wire  logic                 rd_en,
	output psf_pkg::word_info_t        rd_item,
	output logic                       empty
);

	localparam int DEPTH = psf_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	psf_pkg::word_info_t slots [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_item = slots[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots[wr_ptr_q] <= wr_item;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue fill beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!full || rd_en))
		else $error("write into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty)
		else $error("read from an empty queue");

endmodule
`default_nettype wire

/* hdl/psf_back.sv */
// back end: per-site accumulation, verdict, counters and result register
`timescale 1ns / 1ps
`default_nettype none
module psf_back #(
	parameter int MAX_HAPLOTYPES = psf_pkg::MAX_HAPLOTYPES
) (
	input  wire  logic                                 clk,
	input  wire  logic                                 arst_n,
	input  wire  logic [$clog2(MAX_HAPLOTYPES+1)-1:0]  len,
	input  wire  logic                                 remove_on,
	input  wire  psf_pkg::word_info_t                  head,
	input  wire  logic                                 q_empty,
	output logic                                       q_pop,
	output psf_pkg::verdict_t                          verdict,
	output logic                                       empty,
	input  wire  logic                                 pop
);

	localparam int LW = $clog2(MAX_HAPLOTYPES + 1);
	localparam int CW = psf_pkg::COUNT_W;
	localparam int TW = psf_pkg::TOTAL_W;

	logic [LW-1:0]                        acc_cnt_q;
	logic                                 diff_q;
	logic signed [psf_pkg::WORD_W-1:0]    prev_gen_q;
	logic [TW-1:0]                        kept_q;
	logic [TW-1:0]                        nd_q;
	logic                                 out_valid_q;
	psf_pkg::verdict_t                    out_q;

	logic [LW-1:0]          cnt_sum;
	logic                   diff_any;
	logic                   diverges;
	logic                   mono;
	logic [TW-1:0]          kept_next;
	logic [TW-1:0]          nd_next;
	psf_pkg::site_class_t   cls;
	logic                   site_end;

	// a non-final word never needs the result slot
	assign q_pop    = !q_empty && (!head.last || !out_valid_q || pop);
	assign site_end = q_pop && head.last;
	assign empty    = !out_valid_q;
	assign verdict  = out_q;

	always_comb begin
		cnt_sum   = acc_cnt_q + LW'(head.ones);
		diff_any  = diff_q || head.differs;
		mono      = (cnt_sum == '0) || (cnt_sum == len);
		diverges  = ((diff_any || (kept_q == '0)) && (head.gen_position != prev_gen_q))
			|| !remove_on;
		kept_next = kept_q;
		nd_next   = nd_q;
		if (mono) begin
			cls = psf_pkg::CLASS_MONO;
		end else if (!diverges) begin
			cls = psf_pkg::CLASS_NON_DIVERGING;
			if (nd_q != psf_pkg::TOTAL_MAX) begin
				nd_next = nd_q + TW'(1);
			end
		end else begin
			cls = psf_pkg::CLASS_KEPT;
			if (kept_q != psf_pkg::TOTAL_MAX) begin
				kept_next = kept_q + TW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cnt_q   <= '0;
			diff_q      <= 1'b0;
			prev_gen_q  <= psf_pkg::GEN_RESET;
			kept_q      <= '0;
			nd_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (site_end) begin
				acc_cnt_q   <= '0;
				diff_q      <= 1'b0;
				prev_gen_q  <= head.gen_position;
				kept_q      <= kept_next;
				nd_q        <= nd_next;
				out_valid_q <= 1'b1;
			end else begin
				if (q_pop) begin
					acc_cnt_q <= cnt_sum;
					diff_q    <= diff_any;
				end
				if (pop) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (site_end) begin
			out_q.site_kept           <= (cls == psf_pkg::CLASS_KEPT);
			out_q.site_class          <= cls;
			out_q.allele_count        <= CW'(cnt_sum);
			out_q.kept_total          <= kept_next;
			out_q.non_diverging_total <= nd_next;
		end
	end

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		site_end |-> (!out_valid_q || pop))
		else $error("verdict written over an untaken result");

	a_kept_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (kept_q >= $past(kept_q)) && (nd_q >= $past(nd_q)))
		else $error("site counter went backwards");

	a_result_matches: assert property (@(posedge clk) disable iff (!arst_n)
		site_end |=> out_valid_q && (out_q.kept_total == kept_q)
			&& (out_q.non_diverging_total == nd_q))
		else $error("result totals differ from counters");

endmodule
`default_nettype wire

/* hdl/polymorphic_site_filter.sv */
// top level of the polymorphic site filter: configuration and front/back wiring
`timescale 1ns / 1ps
`default_nettype none
// Filters genetic sites streamed as 64-bit haplotype words, one word per item,
// ceil(site_length / 64) items per site (site_length 0 or above MAX_HAPLOTYPES
// means MAX_HAPLOTYPES). Bits of a site's last word past the length are cleared.
// On a site's last word one verdict item comes out: monomorphic sites (no set bit
// or all set) are dropped; with remove_non_diverging set, a polymorphic site that
// repeats the previous site's words (waived until a site has been kept) or its
// genetic position is dropped as non-diverging; the rest are kept. Only the last
// word's gen_position counts. Kept and non-diverging totals saturate at 2^32-1.
// Throughput is one word per clock while the queue has room (else full holds the
// input off): the previous-site store is a read-first single-port memory, so each
// word reads the old word and writes the new one at the same edge. With an empty
// queue a site's last word passes the store read register, the queue and the
// verdict register, in that order, before its verdict is on the result ports. A
// four-entry queue lets the front keep taking words while the verdict register
// is waiting to be popped. Configuration writes are taken at any time (cfg_ready
// is always high) but must only be issued while no site is partially loaded or
// in flight.
// No clearing pass after reset: per-word valid bits make unwritten words read as 0.
module polymorphic_site_filter #(
	parameter int MAX_HAPLOTYPES = psf_pkg::MAX_HAPLOTYPES
) (
	input  wire  logic                                clk,
	input  wire  logic                                arst_n,
	// input items
	input  wire  logic                                push,
	output logic                                      full,
	input  wire  psf_pkg::site_word_t                 site,
	// result items
	output logic                                      empty,
	input  wire  logic                                pop,
	output psf_pkg::verdict_t                         verdict,
	// configuration writes
	input  wire  logic                                cfg_valid,
	output logic                                      cfg_ready,
	input  wire  logic [psf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire  logic [psf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int LW = $clog2(MAX_HAPLOTYPES + 1);
	localparam int SW = psf_pkg::SITE_LENGTH_W;
	// compare width wide enough for both the register and the limit
	localparam int XW = (LW > SW) ? LW : SW;

	logic [SW-1:0] site_length_q;
	logic          remove_q;

	logic [XW-1:0] len_x;
	logic [XW-1:0] max_x;
	logic [LW-1:0] len;

	// front to queue
	logic                 q_push;
	logic                 q_full;
	psf_pkg::word_info_t  q_wr_item;
	// queue to back
	logic                 q_pop;
	logic                 q_empty;
	psf_pkg::word_info_t  q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_length_q <= psf_pkg::SITE_LENGTH_RESET;
			remove_q      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == psf_pkg::CFG_SITE_LENGTH) begin
				site_length_q <= SW'(cfg_data);
			end else if (cfg_index == psf_pkg::CFG_REMOVE) begin
				remove_q <= cfg_data[0];
			end
		end
	end

	// effective site length: zero or oversize means the maximum
	always_comb begin
		len_x = XW'(site_length_q);
		max_x = XW'(MAX_HAPLOTYPES);
		if ((len_x == '0) || (len_x > max_x)) begin
			len = LW'(max_x);
		end else begin
			len = LW'(len_x);
		end
	end

	psf_front #(
		.MAX_HAPLOTYPES (MAX_HAPLOTYPES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.site   (site),
		.len    (len),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (q_wr_item)
	);

	psf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (q_wr_item),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_item (q_head),
		.empty   (q_empty)
	);

	psf_back #(
		.MAX_HAPLOTYPES (MAX_HAPLOTYPES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.len       (len),
		.remove_on (remove_q),
		.head      (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.verdict   (verdict),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
`default_nettype wire

/* dv/polymorphic_site_filter_test.sv */
// self-checking testbench for the polymorphic site filter
`timescale 1ns / 1ps
module polymorphic_site_filter_test;
	import psf_pkg::*;

	localparam int RANDOM_ITEMS = 650;
	// margin after the last expected verdict, before the next step
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SHOWN_MISSES = 10;
	localparam logic signed [WORD_W-1:0] GEN_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [WORD_W-1:0] GEN_BOTTOM = 64'sh8000_0000_0000_0000;
	localparam logic [WORD_W-1:0] ALL_ONES = '1;

	typedef enum logic [1:0] {
		ROW_CFG,   // register write, issued once the filter is idle
		ROW_ITEM,  // input item, verdict (if any) from the predictor
		ROW_CHECK  // input item whose verdict is typed in below
	} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [CFG_INDEX_W-1:0]   reg_index;
		logic [CFG_DATA_W-1:0]    reg_value;
		site_word_t               item;
		verdict_t                 want;
	} plan_row_t;

	localparam int PLAN_ROWS = 22;

	// directed sequence: reset gen position, first-kept waiver, extremes,
	// equal words, equal position, removal off, stray bits, multi-word sites
	// where only the last word's position counts
	plan_row_t plan [PLAN_ROWS] = '{
		'{ROW_CFG, CFG_SITE_LENGTH, 13'd64, '0, '0},
		'{ROW_CFG, CFG_REMOVE, 13'h1FFF, '0, '0},
		// same position as the reset value: dropped although nothing kept yet
		'{ROW_CHECK, '0, '0, '{64'd5, GEN_RESET},
			'{1'b0, CLASS_NON_DIVERGING, 13'd2, 32'd0, 32'd1}},
		// same words as previous site, but the word test is waived
		'{ROW_CHECK, '0, '0, '{64'd5, 64'sd3},
			'{1'b1, CLASS_KEPT, 13'd2, 32'd1, 32'd1}},
		'{ROW_CHECK, '0, '0, '{64'd0, 64'sd0},
			'{1'b0, CLASS_MONO, 13'd0, 32'd1, 32'd1}},
		'{ROW_CHECK, '0, '0, '{ALL_ONES, GEN_TOP},
			'{1'b0, CLASS_MONO, 13'd64, 32'd1, 32'd1}},
		'{ROW_CHECK, '0, '0, '{64'h8000_0000_0000_0000, GEN_BOTTOM},
			'{1'b1, CLASS_KEPT, 13'd1, 32'd2, 32'd1}},
		// repeat of the previous site's words
		'{ROW_CHECK, '0, '0, '{64'h8000_0000_0000_0000, 64'sd0},
			'{1'b0, CLASS_NON_DIVERGING, 13'd1, 32'd2, 32'd2}},
		// new words, repeated position
		'{ROW_CHECK, '0, '0, '{64'd3, 64'sd0},
			'{1'b0, CLASS_NON_DIVERGING, 13'd2, 32'd2, 32'd3}},
		'{ROW_CFG, CFG_REMOVE, 13'h1FFE, '0, '0},
		'{ROW_CHECK, '0, '0, '{64'd3, 64'sd0},
			'{1'b1, CLASS_KEPT, 13'd2, 32'd3, 32'd3}},
		'{ROW_CFG, CFG_SITE_LENGTH, 13'd1, '0, '0},
		// stray bits above the length are cleared
		'{ROW_CHECK, '0, '0, '{ALL_ONES, 64'sd1},
			'{1'b0, CLASS_MONO, 13'd1, 32'd3, 32'd3}},
		'{ROW_CHECK, '0, '0, '{64'hFFFF_FFFF_FFFF_FFFE, 64'sd2},
			'{1'b0, CLASS_MONO, 13'd0, 32'd3, 32'd3}},
		'{ROW_CFG, CFG_SITE_LENGTH, 13'd65, '0, '0},
		'{ROW_CFG, CFG_REMOVE, 13'd1, '0, '0},
		'{ROW_ITEM, '0, '0, '{64'd0, 64'sd1}, '0},
		'{ROW_CHECK, '0, '0, '{64'hFFFE, 64'sd9},
			'{1'b0, CLASS_MONO, 13'd0, 32'd3, 32'd3}},
		'{ROW_ITEM, '0, '0, '{64'd1, 64'sd100}, '0},
		'{ROW_CHECK, '0, '0, '{64'd1, 64'sd10},
			'{1'b1, CLASS_KEPT, 13'd2, 32'd4, 32'd3}},
		// first word's position differs, last word's repeats the previous one
		'{ROW_ITEM, '0, '0, '{64'd2, 64'sd55}, '0},
		'{ROW_CHECK, '0, '0, '{64'd0, 64'sd10},
			'{1'b0, CLASS_NON_DIVERGING, 13'd1, 32'd4, 32'd4}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	site_word_t site = '0;
	logic empty;
	logic pop = 1'b0;
	verdict_t verdict;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	polymorphic_site_filter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.site      (site),
		.empty     (empty),
		.pop       (pop),
		.verdict   (verdict),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// filter model state, advanced once per accepted input item
	logic [SITE_LENGTH_W-1:0] len_reg = SITE_LENGTH_RESET;
	logic                     remove_reg = 1'b0;
	logic [WORD_W-1:0]        prev_words [MAX_HAPLOTYPES / WORD_W];
	int unsigned              word_slot = 0;
	int unsigned              ones_tally = 0;
	logic                     site_differs = 1'b0;
	logic signed [WORD_W-1:0] prev_gen = GEN_RESET;
	logic [TOTAL_W-1:0]       kept_sum = '0;
	logic [TOTAL_W-1:0]       dropped_sum = '0;

	verdict_t verdicts_due [$];
	int errors = 0;
	int rand_items = 0;

	initial begin
		for (int i = 0; i < MAX_HAPLOTYPES / WORD_W; i++) begin
			prev_words[i] = '0;
		end
	end

	initial begin
		forever #5 clk = ~clk;
	end

	// haplotypes per site as the filter sees it: 0 and oversize mean the maximum
	function automatic int unsigned site_span();
		if (len_reg == 0 || len_reg > MAX_HAPLOTYPES) begin
			return MAX_HAPLOTYPES;
		end
		return len_reg;
	endfunction

	// fold one word into the current site; on its last word produce the verdict
	task automatic judge_word(input site_word_t w, output logic emits, output verdict_t v);
		int unsigned span;
		int unsigned nwords;
		int unsigned slot;
		int unsigned left;
		logic [WORD_W-1:0] bits;
		logic diverges;
		span = site_span();
		nwords = (span + WORD_W - 1) / WORD_W;
		slot = (word_slot >= nwords) ? nwords - 1 : word_slot;
		left = span - slot * WORD_W;
		bits = w.haplotype_word;
		if (left < WORD_W) begin
			bits &= (64'd1 << left) - 64'd1;
		end
		if (bits != prev_words[slot]) begin
			site_differs = 1'b1;
		end
		prev_words[slot] = bits;
		ones_tally += $countones(bits);
		emits = 1'b0;
		v = '0;
		if (slot + 1 < nwords) begin
			word_slot = slot + 1;
			return;
		end
		// word test waived until something is kept; position test always applies
		diverges = ((site_differs || kept_sum == 0) && w.gen_position != prev_gen)
			|| !remove_reg;
		prev_gen = w.gen_position;
		v.allele_count = ones_tally[COUNT_W-1:0];
		if (ones_tally == 0 || ones_tally == span) begin
			v.site_class = CLASS_MONO;
		end else if (!diverges) begin
			v.site_class = CLASS_NON_DIVERGING;
			if (dropped_sum != TOTAL_MAX) begin
				dropped_sum++;
			end
		end else begin
			v.site_class = CLASS_KEPT;
			v.site_kept = 1'b1;
			if (kept_sum != TOTAL_MAX) begin
				kept_sum++;
			end
		end
		v.kept_total = kept_sum;
		v.non_diverging_total = dropped_sum;
		word_slot = 0;
		ones_tally = 0;
		site_differs = 1'b0;
		emits = 1'b1;
	endtask

	// offer one item after a random gap; typed verdicts override the model's
	task automatic push_word(input site_word_t w, input logic calm, input logic typed,
			input verdict_t want);
		int gap;
		logic emits;
		verdict_t v;
		verdict_t due;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			@(negedge clk) push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		site <= w;
		@(posedge clk);
		while (full) @(posedge clk);
		judge_word(w, emits, v);
		if (emits) begin
			due = typed ? want : v;
			verdicts_due = {verdicts_due, due};
		end
	endtask

	// stop offering items and let every outstanding verdict come out
	task automatic drain();
		@(negedge clk) push <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_SITE_LENGTH) begin
			len_reg = value;
		end else if (idx == CFG_REMOVE) begin
			remove_reg = value[0];
		end
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// one whole site: random, a repeat of the stored site, sparse, empty,
	// dense or full, with stray bits and a position chosen to hit the drop rules
	task automatic send_site(input logic calm);
		logic [WORD_W-1:0] words [MAX_HAPLOTYPES / WORD_W];
		int unsigned span;
		int unsigned nwords;
		int unsigned left;
		int unsigned hit;
		int unsigned shape;
		logic signed [WORD_W-1:0] gen;
		site_word_t w;
		span = site_span();
		nwords = (span + WORD_W - 1) / WORD_W;
		shape = $urandom_range(0, 99);
		for (int i = 0; i < nwords; i++) begin
			if (shape < 30) begin
				words[i] = {$urandom, $urandom};
			end else if (shape < 55) begin
				words[i] = prev_words[i];
			end else if (shape < 75) begin
				words[i] = '0;
			end else begin
				words[i] = '1;
			end
		end
		// sparse and dense sites: a few bits away from monomorphic
		if ((shape >= 55 && shape < 65) || (shape >= 75 && shape < 85)) begin
			repeat ($urandom_range(1, 3)) begin
				hit = $urandom_range(0, span - 1);
				words[hit / WORD_W][hit % WORD_W] ^= 1'b1;
			end
		end
		left = span - (nwords - 1) * WORD_W;
		if (left < WORD_W && $urandom_range(0, 1) == 1) begin
			words[nwords - 1] |= {$urandom, $urandom} & ~((64'd1 << left) - 64'd1);
		end
		case ($urandom_range(0, 9))
			5, 6: gen = prev_gen;
			7: gen = GEN_RESET;
			8: gen = GEN_TOP;
			9: gen = GEN_BOTTOM;
			default: gen = {$urandom, $urandom};
		endcase
		for (int i = 0; i < nwords; i++) begin
			w.haplotype_word = words[i];
			// only the last word's position matters; earlier ones are noise
			w.gen_position = (i == nwords - 1) ? gen : {$urandom, $urandom};
			push_word(w, calm, 1'b0, '0);
			rand_items++;
		end
	endtask

	task automatic note(input string text);
		errors++;
		if (errors <= SHOWN_MISSES) begin
			$display("%0s", text);
		end
	endtask

	task automatic check_field(input string field, input logic [TOTAL_W-1:0] want,
			input logic [TOTAL_W-1:0] got);
		if (got !== want) begin
			note($sformatf("verdict %0s: expected %0h, got %0h", field, want, got));
		end
	endtask

	// result side: random pop gaps with occasional back-to-back stretches
	initial begin : verdict_taker
		verdict_t want;
		int gap;
		int served;
		logic calm;
		served = 0;
		calm = 1'b0;
		@(posedge arst_n);
		forever begin
			if (served % 20 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			gap = calm ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				@(negedge clk) pop <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			served++;
			if (verdicts_due.size() == 0) begin
				note($sformatf("verdict with nothing expected: class %0d count %0d",
					verdict.site_class, verdict.allele_count));
			end else begin
				want = verdicts_due.pop_front();
				check_field("site_kept", TOTAL_W'(want.site_kept),
					TOTAL_W'(verdict.site_kept));
				check_field("site_class", TOTAL_W'(want.site_class),
					TOTAL_W'(verdict.site_class));
				check_field("allele_count", TOTAL_W'(want.allele_count),
					TOTAL_W'(verdict.allele_count));
				check_field("kept_total", want.kept_total, verdict.kept_total);
				check_field("non_diverging_total", want.non_diverging_total,
					verdict.non_diverging_total);
			end
		end
	end

	// hard stop in case the filter hangs
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("polymorphic_site_filter_test: errors");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int sites;
		logic calm;
		logic [CFG_DATA_W-1:0] len_pick;
		logic big_phase;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed table
		for (int r = 0; r < PLAN_ROWS; r++) begin
			if (plan[r].kind == ROW_CFG) begin
				write_reg(plan[r].reg_index, plan[r].reg_value);
			end else begin
				push_word(plan[r].item, 1'b0, plan[r].kind == ROW_CHECK, plan[r].want);
			end
		end

		// random phases, each with its own length and removal setting;
		// the first three exercise zero, oversize and the full length
		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			big_phase = 1'b0;
			case (phase)
				0: len_pick = 13'd0;
				1: len_pick = 13'd8191;
				2: len_pick = 13'd4096;
				default: begin
					case ($urandom_range(0, 9))
						0: len_pick = CFG_DATA_W'(WORD_W * $urandom_range(1, 3));
						1: len_pick = CFG_DATA_W'($urandom_range(4095, 8191));
						default: len_pick = CFG_DATA_W'($urandom_range(1, 200));
					endcase
				end
			endcase
			big_phase = (len_pick == 0 || len_pick > 1024);
			write_reg(CFG_SITE_LENGTH, len_pick);
			// upper data bits are random; only bit 0 counts
			write_reg(CFG_REMOVE, {12'($urandom_range(0, 4095)),
				($urandom_range(0, 2) != 0)});
			sites = big_phase ? $urandom_range(1, 2) : $urandom_range(3, 12);
			calm = ($urandom_range(0, 3) == 0);
			repeat (sites) send_site(calm);
			phase++;
		end

		drain();
		if (errors == 0) begin
			$display("polymorphic_site_filter_test: clean");
		end else begin
			$display("polymorphic_site_filter_test: errors");
		end
		$finish;
	end

endmodule
